// ===== src/slpm_pkg.sv =====
package slpm_pkg;

	// code point width
	localparam int unsigned CP_W = 21;

	// pattern characters with a special meaning
	localparam logic [CP_W-1:0] CH_PERCENT    = 21'd37;
	localparam logic [CP_W-1:0] CH_UNDERSCORE = 21'd95;
	localparam logic [CP_W-1:0] CH_BACKSLASH  = 21'd92;

	// input operation codes
	typedef enum logic [2:0] {
		OP_PAT_START = 3'd0,
		OP_PAT_CHAR  = 3'd1,
		OP_SUB_START = 3'd2,
		OP_SUB_CHAR  = 3'd3,
		OP_SUB_END   = 3'd4
	} op_t;

	// compiled pattern element kinds
	typedef enum logic [1:0] {
		KIND_LIT = 2'd0,
		KIND_ONE = 2'd1,
		KIND_RUN = 2'd2
	} kind_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic            clear;
		logic            start;
		logic            step;
		logic            wr;
		kind_t           wr_kind;
		logic [CP_W-1:0] wr_cp;
		logic [CP_W-1:0] sub_cp;
	} cell_ctl_t;

endpackage

// ===== src/slpm_cell.sv =====
module slpm_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned LW  = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  slpm_pkg::cell_ctl_t ctl,
	input  logic [LW-1:0]      len,
	input  logic               fwd_in,
	input  logic               carry_in,
	output logic               fwd_out,
	output logic               carry_out,
	output logic               act
);
	import slpm_pkg::*;

	kind_t           kind_q;
	logic [CP_W-1:0] cp_q;
	logic            act_q;
	logic            used;
	logic            is_run;
	logic            raw;
	logic            closed;

	// this element lies inside the loaded pattern
	assign used   = (LW'(IDX) < len);
	assign is_run = used && (kind_q == KIND_RUN);

	// element storage, written when it is the next free slot
	always_ff @(posedge clk) begin
		if (ctl.wr && (len == LW'(IDX))) begin
			kind_q <= ctl.wr_kind;
			cp_q   <= ctl.wr_cp;
		end
	end

	// advance into the next position on one-char or literal match
	assign fwd_out = ctl.step && act_q && used &&
		((kind_q == KIND_ONE) || ((kind_q == KIND_LIT) && (cp_q == ctl.sub_cp)));

	// new position state before and after run closure
	assign raw       = ctl.start ? fwd_in : (fwd_in || (act_q && is_run));
	assign closed    = raw || carry_in;
	assign carry_out = closed && is_run;

	// active flag of this position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (ctl.clear) begin
			act_q <= 1'b0;
		end else if (ctl.start || ctl.step) begin
			act_q <= closed;
		end
	end

	assign act = act_q;

endmodule

// ===== src/sql_like_pattern_matcher.sv =====
// SQL LIKE matcher over decoded code points. Load a pattern with a pattern start
// (which takes the escape code point) followed by pattern chars, then scan any
// number of subjects with subject start, subject chars and subject end; only
// subject end returns a transaction (matched, null, overflow). '%' matches any run,
// '_' any single code point, newlines included; an escape left open at the end of
// the pattern counts as a literal escape character. The pattern lives in a row of
// MAX_PATTERN cells, each holding one element and its active flag, and every
// subject char moves all cells at once, so one item is taken per clock cycle, with
// the result registered behind the input. The input stalls in two cases: the first
// subject item after a pattern that ends in an open escape waits while the block
// stores that literal, and a subject end waits while the previous result is still
// held by the receiver. The clock period is set by the run closure, which ripples
// like a carry through the cells across a block of consecutive '%' elements.
module sql_like_pattern_matcher #(
	parameter int unsigned MAX_PATTERN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// code_point [20:0], escape_char [41:21], zero [47:42]
	input  logic [47:0] s_axis_tdata,
	// op [2:0], row_null [3]
	input  logic [3:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// matched [0], zero [7:1]
	output logic [7:0]  m_axis_tdata,
	// result_null [0], pattern_overflow [1]
	output logic [1:0]  m_axis_tuser
);
	import slpm_pkg::*;

	localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

	// accepted item
	logic            busy_q;
	logic [2:0]      op_q;
	logic [CP_W-1:0] cp_q;
	logic [CP_W-1:0] esc_in_q;
	logic            row_null_q;

	// pattern state
	logic [LW-1:0]   len_q;
	logic [CP_W-1:0] esc_q;
	logic            pend_q;
	logic            ovf_q;
	logic            act_top_q;

	// result register
	logic            m_valid_q;
	logic            matched_q;
	logic            null_q;
	logic            ovf_out_q;

	cell_ctl_t           ctl;
	logic                is_subject;
	logic                need_finish;
	logic                can_exec;
	logic                done;
	logic                append;
	kind_t               app_kind;
	logic [CP_W-1:0]     app_cp;
	logic                full;
	logic [MAX_PATTERN:0] fwd;
	logic [MAX_PATTERN:0] carry;
	logic [MAX_PATTERN:0] act_vec;

	// sequencing of the held item
	assign is_subject  = (op_q == OP_SUB_START) || (op_q == OP_SUB_CHAR) ||
		(op_q == OP_SUB_END);
	assign need_finish = busy_q && pend_q && is_subject;
	assign can_exec    = !((op_q == OP_SUB_END) && m_valid_q && !m_axis_tready);
	assign done        = busy_q && !need_finish && can_exec;
	assign full        = (len_q == LW'(MAX_PATTERN));

	assign s_axis_tready = !busy_q || done;

	// element to append, if any
	always_comb begin
		append   = 1'b0;
		app_kind = KIND_LIT;
		app_cp   = cp_q;
		if (need_finish) begin
			append = 1'b1;
			app_cp = esc_q;
		end else if (done && (op_q == OP_PAT_CHAR)) begin
			if (pend_q) begin
				append = 1'b1;
			end else if (cp_q == esc_q) begin
				append = 1'b0;
			end else if (cp_q == CH_PERCENT) begin
				append   = 1'b1;
				app_kind = KIND_RUN;
				app_cp   = '0;
			end else if (cp_q == CH_UNDERSCORE) begin
				append   = 1'b1;
				app_kind = KIND_ONE;
				app_cp   = '0;
			end else begin
				append = 1'b1;
			end
		end
	end

	// broadcast to the cells
	always_comb begin
		ctl.clear   = done && (op_q == OP_PAT_START);
		ctl.start   = done && (op_q == OP_SUB_START);
		ctl.step    = done && (op_q == OP_SUB_CHAR);
		ctl.wr      = append && !full;
		ctl.wr_kind = app_kind;
		ctl.wr_cp   = app_cp;
		ctl.sub_cp  = cp_q;
	end

	// row of pattern cells
	assign fwd[0]   = ctl.start;
	assign carry[0] = 1'b0;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		slpm_cell #(
			.IDX (j),
			.LW  (LW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.len       (len_q),
			.fwd_in    (fwd[j]),
			.carry_in  (carry[j]),
			.fwd_out   (fwd[j+1]),
			.carry_out (carry[j+1]),
			.act       (act_vec[j])
		);
	end

	assign act_vec[MAX_PATTERN] = act_top_q;

	// input capture
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q       <= s_axis_tuser[2:0];
			row_null_q <= s_axis_tuser[3];
			cp_q       <= s_axis_tdata[20:0];
			esc_in_q   <= s_axis_tdata[41:21];
		end
	end

	// control and pattern state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			len_q     <= '0;
			esc_q     <= CH_BACKSLASH;
			pend_q    <= 1'b0;
			ovf_q     <= 1'b0;
			act_top_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end

			// element append or overflow
			if (append) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + LW'(1);
				end
			end

			// escape tracking
			if (need_finish) begin
				pend_q <= 1'b0;
			end else if (done && (op_q == OP_PAT_CHAR)) begin
				pend_q <= !pend_q && (cp_q == esc_q);
			end

			// pattern start
			if (ctl.clear) begin
				len_q     <= '0;
				esc_q     <= esc_in_q;
				pend_q    <= 1'b0;
				ovf_q     <= 1'b0;
				act_top_q <= 1'b0;
			end else if (ctl.start || ctl.step) begin
				act_top_q <= fwd[MAX_PATTERN] || carry[MAX_PATTERN];
			end

			// result handshake
			if (done && (op_q == OP_SUB_END)) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (done && (op_q == OP_SUB_END)) begin
			matched_q <= !row_null_q && !ovf_q && act_vec[len_q];
			null_q    <= row_null_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, matched_q};
	assign m_axis_tuser  = {ovf_out_q, null_q};

endmodule

// ===== sim/sql_like_pattern_matcher_tb.sv =====
module sql_like_pattern_matcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import slpm_pkg::*;

	localparam int unsigned MAXP = 64;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned RANDOM_ITEMS = 500;
	localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
	localparam logic [CP_W-1:0] CH_A = 21'd97;
	localparam logic [CP_W-1:0] CH_B = 21'd98;
	localparam logic [CP_W-1:0] CH_NL = 21'd10;
	// op codes the block ignores
	localparam logic [2:0] OP_RESERVED_LO = 3'd5;
	localparam logic [2:0] OP_RESERVED_HI = 3'd7;

	typedef struct packed {
		logic matched;
		logic is_null;
		logic overflow;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [3:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	sql_like_pattern_matcher #(
		.MAX_PATTERN(MAXP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// compiled pattern and nfa state of the matcher
	kind_t           pat_kind [MAXP];
	logic [CP_W-1:0] pat_cp [MAXP];
	int unsigned     pat_len = 0;
	logic [CP_W-1:0] esc_code = CH_BACKSLASH;
	bit              esc_pending = 1'b0;
	bit              pat_overflow = 1'b0;
	logic [MAXP:0]   active = '0;

	verdict_t    expected_verdicts [$];
	int unsigned failures = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;

	// receiver stall control
	bit          hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned rx_tick = 0;
	int unsigned rx_mode = 0;

	function automatic void pat_append(kind_t kind, logic [CP_W-1:0] cp);
		if (pat_len >= MAXP) begin
			pat_overflow = 1'b1;
		end else begin
			pat_kind[pat_len] = kind;
			pat_cp[pat_len] = cp;
			pat_len++;
		end
	endfunction

	// an escape still open when the subject begins is a literal escape char
	function automatic void flush_escape();
		if (esc_pending) begin
			esc_pending = 1'b0;
			pat_append(KIND_LIT, esc_code);
		end
	endfunction

	// '%' positions also activate the position after them, rippling forward
	function automatic logic [MAXP:0] close_runs(logic [MAXP:0] v);
		for (int unsigned j = 0; j < pat_len; j++) begin
			if (v[j] && pat_kind[j] == KIND_RUN)
				v[j+1] = 1'b1;
		end
		return v;
	endfunction

	// advance the matcher by one transaction; returns 1 when a verdict is due
	function automatic bit like_step(input logic [2:0] op, input logic [CP_W-1:0] cp,
		input logic [CP_W-1:0] esc, input logic rnull, output verdict_t v);
		logic [MAXP:0] nxt;
		bit            due;
		due = 1'b0;
		v = '0;
		case (op)
			OP_PAT_START: begin
				pat_len = 0;
				esc_code = esc;
				esc_pending = 1'b0;
				pat_overflow = 1'b0;
				active = '0;
			end
			OP_PAT_CHAR: begin
				if (esc_pending) begin
					esc_pending = 1'b0;
					pat_append(KIND_LIT, cp);
				end else if (cp == esc_code) begin
					esc_pending = 1'b1;
				end else if (cp == CH_PERCENT) begin
					pat_append(KIND_RUN, '0);
				end else if (cp == CH_UNDERSCORE) begin
					pat_append(KIND_ONE, '0);
				end else begin
					pat_append(KIND_LIT, cp);
				end
			end
			OP_SUB_START: begin
				flush_escape();
				active = '0;
				active[0] = 1'b1;
				active = close_runs(active);
			end
			OP_SUB_CHAR: begin
				flush_escape();
				nxt = '0;
				for (int unsigned j = 0; j < pat_len; j++) begin
					if (active[j]) begin
						if (pat_kind[j] == KIND_RUN)
							nxt[j] = 1'b1;
						else if (pat_kind[j] == KIND_ONE || pat_cp[j] == cp)
							nxt[j+1] = 1'b1;
					end
				end
				active = close_runs(nxt);
			end
			OP_SUB_END: begin
				flush_escape();
				v.matched = !rnull && !pat_overflow && active[pat_len];
				v.is_null = rnull;
				v.overflow = pat_overflow;
				due = 1'b1;
			end
			default: begin
			end
		endcase
		return due;
	endfunction

	// send one transaction, with bursts and gaps; called and left at a falling edge
	task automatic send_item(input logic [2:0] op, input logic [CP_W-1:0] cp,
		input logic [CP_W-1:0] esc, input logic rnull);
		int unsigned gap;
		verdict_t    v;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, esc, cp};
		s_axis_tuser <= {rnull, op};
		do @(posedge clk); while (!s_axis_tready);
		if (like_step(op, cp, esc, rnull, v))
			expected_verdicts.push_back(v);
		@(negedge clk);
	endtask

	function automatic logic [CP_W-1:0] any_cp();
		return CP_W'($urandom_range(0, CP_MAX));
	endfunction

	task automatic start_pattern(input logic [CP_W-1:0] esc);
		send_item(OP_PAT_START, any_cp(), esc, 1'($urandom_range(0, 1)));
	endtask

	task automatic pattern_char(input logic [CP_W-1:0] cp);
		send_item(OP_PAT_CHAR, cp, any_cp(), 1'($urandom_range(0, 1)));
	endtask

	task automatic start_subject();
		send_item(OP_SUB_START, any_cp(), any_cp(), 1'($urandom_range(0, 1)));
	endtask

	task automatic subject_char(input logic [CP_W-1:0] cp);
		send_item(OP_SUB_CHAR, cp, any_cp(), 1'($urandom_range(0, 1)));
	endtask

	task automatic end_subject(input logic rnull);
		send_item(OP_SUB_END, any_cp(), any_cp(), rnull);
	endtask

	// small alphabets so that matches are frequent
	function automatic logic [CP_W-1:0] pick_pattern_char(logic [CP_W-1:0] esc);
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r <= 5) return CH_A;
		if (r <= 8) return CH_B;
		if (r <= 10) return CH_PERCENT;
		if (r <= 12) return CH_UNDERSCORE;
		if (r == 13) return esc;
		if (r == 14) return CH_NL;
		return any_cp();
	endfunction

	function automatic logic [CP_W-1:0] pick_subject_char();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r <= 7) return CH_A;
		if (r <= 11) return CH_B;
		if (r == 12) return CH_NL;
		if (r == 13) return CH_PERCENT;
		if (r == 14) return CH_UNDERSCORE;
		return any_cp();
	endfunction

	function automatic logic [CP_W-1:0] pick_escape();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r <= 5) return CH_BACKSLASH;
		if (r == 6) return CH_PERCENT;
		if (r == 7) return CH_UNDERSCORE;
		if (r == 8) return CH_A;
		return any_cp();
	endfunction

	// field extremes, every op and the corner cases of pattern compilation
	task automatic test_directed();
		// subject end straight after reset: empty pattern, nothing active
		end_subject(1'b0);
		// escape at the top of the code space, left open at the end of the pattern
		start_pattern(CP_MAX);
		pattern_char('0);
		pattern_char(CH_PERCENT);
		pattern_char(CH_UNDERSCORE);
		pattern_char(CP_MAX);
		start_subject();
		subject_char('0);
		subject_char(CH_A);
		subject_char(CH_NL);
		subject_char(CP_MAX);
		end_subject(1'b0);
		// escape equal to '%': it only escapes; '_' still matches a newline
		start_pattern(CH_PERCENT);
		pattern_char(CH_PERCENT);
		pattern_char(CH_PERCENT);
		pattern_char(CH_UNDERSCORE);
		start_subject();
		subject_char(CH_PERCENT);
		subject_char(CH_NL);
		end_subject(1'b0);
		end_subject(1'b1);
		// pattern grows during a subject, then ignored op codes
		subject_char(CH_A);
		pattern_char(CH_A);
		end_subject(1'b0);
		send_item(OP_RESERVED_LO, any_cp(), any_cp(), 1'b1);
		send_item(OP_RESERVED_HI, CP_MAX, CP_MAX, 1'b0);
	endtask

	// element capacity: exactly full, overflow by the trailing escape, long pattern
	task automatic test_pattern_capacity();
		start_pattern(CH_BACKSLASH);
		repeat (MAXP - 1) pattern_char(CH_A);
		pattern_char(CH_BACKSLASH);
		start_subject();
		repeat (MAXP - 1) subject_char(CH_A);
		subject_char(CH_BACKSLASH);
		end_subject(1'b0);

		start_pattern(CH_BACKSLASH);
		repeat (MAXP) pattern_char(CH_A);
		pattern_char(CH_BACKSLASH);
		start_subject();
		repeat (MAXP) subject_char(CH_A);
		end_subject(1'b0);
		end_subject(1'b1);

		start_pattern(CH_BACKSLASH);
		pattern_char(CH_PERCENT);
		repeat (MAXP + 6) pattern_char(pick_pattern_char(CH_BACKSLASH));
		start_subject();
		repeat (5) subject_char(pick_subject_char());
		end_subject(1'b0);
	endtask

	// well-formed pattern/subject sequences with random content, plus noise
	task automatic test_random_sequences();
		int unsigned     sent;
		int unsigned     plen;
		int unsigned     slen;
		logic [2:0]      op;
		logic [CP_W-1:0] esc;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				op = 3'($urandom_range(0, OP_RESERVED_HI));
				send_item(op, any_cp(), any_cp(), 1'($urandom_range(0, 1)));
				if (op <= OP_SUB_END)
					sent++;
			end else begin
				esc = pick_escape();
				start_pattern(esc);
				plen = ($urandom_range(0, 15) == 0) ? $urandom_range(MAXP - 4, MAXP + 6)
					: $urandom_range(0, 8);
				repeat (plen) pattern_char(pick_pattern_char(esc));
				sent += plen + 1;
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 19) != 0) begin
						start_subject();
						sent++;
					end
					slen = $urandom_range(0, 10);
					repeat (slen) subject_char(pick_subject_char());
					end_subject($urandom_range(0, 9) == 0);
					sent += slen + 1;
				end
			end
		end
	endtask

	// receiver holds off long enough for the block to back up and stall its input
	task automatic test_output_backpressure();
		hold_req = 1'b1;
		start_pattern(CH_BACKSLASH);
		pattern_char(CH_A);
		pattern_char(CH_PERCENT);
		repeat (40) begin
			start_subject();
			subject_char(pick_subject_char());
			end_subject($urandom_range(0, 7) == 0);
		end
	endtask

	// receiver: long holds on request, otherwise a rotating stall pattern
	always @(negedge clk) begin
		rx_tick++;
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_tick % 97 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= (rx_tick % 8 < 5);
			endcase
		end
	end

	// result checking against the oldest expected verdict
	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_verdicts.size() == 0) begin
				$error("unexpected result transaction: matched %0b null %0b overflow %0b",
					m_axis_tdata[0], m_axis_tuser[0], m_axis_tuser[1]);
				failures++;
			end else begin
				exp_v = expected_verdicts.pop_front();
				if (m_axis_tdata[0] !== exp_v.matched) begin
					$error("matched: expected %0b, actual %0b", exp_v.matched, m_axis_tdata[0]);
					failures++;
				end
				if (m_axis_tuser[0] !== exp_v.is_null) begin
					$error("result_null: expected %0b, actual %0b", exp_v.is_null,
						m_axis_tuser[0]);
					failures++;
				end
				if (m_axis_tuser[1] !== exp_v.overflow) begin
					$error("pattern_overflow: expected %0b, actual %0b", exp_v.overflow,
						m_axis_tuser[1]);
					failures++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("sql_like_pattern_matcher_tb failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_pattern_capacity();
		test_output_backpressure();
		test_random_sequences();

		s_axis_tvalid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (expected_verdicts.size() != 0 || failures != 0) begin
			$display("sql_like_pattern_matcher_tb failed");
		end else begin
			$display("sql_like_pattern_matcher_tb passed");
		end
		$finish;
	end

endmodule
